>>> sv/spd_pkg.sv
// Package for the shortest-path block: sizes, function codes and the edge record.
// Used by the top level of the block; depends on nothing.
package spd_pkg;
   localparam int MaxNodes = 64;
   localparam int MaxEdges = 256;
   localparam int NodeW = 7;
   localparam int DistW = 20;
   localparam int WeightW = 12;
   localparam int NidxW = $clog2(MaxNodes);
   localparam int EidxW = $clog2(MaxEdges);
   localparam int EcntW = EidxW + 1;
   localparam int EdgeW = 2 * NodeW + WeightW;
   localparam logic [DistW-1:0] Unreachable = DistW'(1000000);
   localparam logic [1:0] FuncClear = 2'd0;
   localparam logic [1:0] FuncAdd = 2'd1;
   localparam logic [1:0] FuncRun = 2'd2;
   localparam logic [NodeW-1:0] NodesReset = NodeW'(MaxNodes);
   localparam int AddrW = 1;

   typedef struct packed {
      logic [NodeW-1:0] a;
      logic [NodeW-1:0] b;
      logic [WeightW-1:0] w;
   } edge_type;
endpackage

>>> sv/spd_ram.sv
// Generic single-port RAM with a registered read.
// Depends on nothing.
module spd_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wdata,
   output logic [Width-1:0]         rdata
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;
endmodule

>>> sv/shortest_path_dijkstra.sv
// Top level of the shortest-path block: APB register, edge store and run sequencer.
// Depends on spd_pkg and spd_ram.
//
//   channel   direction  handshake           payload
//   req_      in         req_valid/ready     func, node_a, node_b, weight
//   rsp_      out        rsp_valid/ready     node, distance, parent, last, edges_dropped
//   csr_      in         APB psel/penable    node_count
//
// A clear or add request is taken while idle. A run initializes the N nodes, then
// does up to N passes, each a scan of the nodes through the shared compare unit, a step
// to mark the node finished, a visit of each stored edge and a step to close the sweep.
// A last scan finds no node, then each node's result is shown in turn. Reset is synchronous.
// A stalled result holds the sequencer; no request is taken during a run.
module shortest_path_dijkstra (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_func,
   input  logic [spd_pkg::NodeW-1:0]     req_node_a,
   input  logic [spd_pkg::NodeW-1:0]     req_node_b,
   input  logic [spd_pkg::WeightW-1:0]   req_weight,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [spd_pkg::NodeW-1:0]     rsp_node,
   output logic [spd_pkg::DistW-1:0]     rsp_distance,
   output logic [spd_pkg::NodeW-1:0]     rsp_parent,
   output logic                          rsp_last,
   output logic                          rsp_edges_dropped,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [spd_pkg::AddrW-1:0]     csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);
   import spd_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_INIT, S_SCAN, S_MARK, S_EDGE_RD, S_EDGE_A, S_EDGE_B, S_UPD, S_EMIT,
      S_EMIT_W
   } state_type;

   state_type state_ff;
   logic [NodeW-1:0] count_ff;
   logic [EcntW-1:0] etotal_ff;
   logic overflow_ff;
   logic [NodeW-1:0] n_ff, start_ff, i_ff, x_ff, best_x_ff, nb_ff;
   logic [DistW-1:0] best_ff, dx_ff, cand_ff;
   logic [EcntW-1:0] e_ff;
   logic second_ff;
   logic out_valid_ff;
   logic [NodeW-1:0] out_node_ff, out_par_ff;
   logic [DistW-1:0] out_dist_ff;
   logic out_last_ff;

   edge_type e_wdata, e_rdata;
   logic e_we;
   logic [EidxW-1:0] e_addr;
   logic d_we, p_we;
   logic [NidxW-1:0] n_addr;
   // The top bit of a distance entry marks the node as finished.
   logic [DistW:0] d_wdata, d_rdata;
   logic [NodeW-1:0] p_wdata, p_rdata;

   logic [NodeW-1:0] n_in, node_m1, other;
   logic edge_ok, hit_a, hit_b, scan_better;
   logic [DistW-1:0] sum;

   assign csr_pready = 1'b1;
   assign csr_prdata = {{(32-NodeW){1'b0}}, count_ff};
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = out_valid_ff;
   assign rsp_node = out_node_ff;
   assign rsp_distance = out_dist_ff;
   assign rsp_parent = out_par_ff;
   assign rsp_last = out_last_ff;
   assign rsp_edges_dropped = overflow_ff;

   always_comb begin
      n_in = count_ff;
      if (count_ff == '0) n_in = NodeW'(1);
      if (count_ff > NodeW'(MaxNodes)) n_in = NodeW'(MaxNodes);
   end

   assign node_m1 = i_ff - NodeW'(1);
   assign edge_ok = (e_rdata.a != '0) && (e_rdata.a <= n_ff) &&
                    (e_rdata.b != '0) && (e_rdata.b <= n_ff);
   assign hit_a = edge_ok && (e_rdata.a == x_ff);
   assign hit_b = edge_ok && (e_rdata.b == x_ff);
   assign other = second_ff ? e_rdata.a : e_rdata.b;
   assign scan_better = (i_ff != NodeW'(1)) && !d_rdata[DistW] &&
                        (d_rdata[DistW-1:0] < best_ff);
   // Shared adder: candidate distance through the extracted node.
   assign sum = dx_ff + DistW'(e_rdata.w);

   always_comb begin
      e_we = 1'b0;
      e_addr = e_ff[EidxW-1:0];
      e_wdata = '{a: req_node_a, b: req_node_b, w: req_weight};
      d_we = 1'b0;
      p_we = 1'b0;
      n_addr = node_m1[NidxW-1:0];
      d_wdata = {1'b0, Unreachable};
      p_wdata = '0;
      unique case (state_ff)
         S_IDLE: begin
            e_addr = etotal_ff[EidxW-1:0];
            e_we = req_valid && (req_func == FuncAdd) &&
                   (etotal_ff < EcntW'(MaxEdges));
         end
         S_INIT: begin
            d_we = 1'b1;
            p_we = 1'b1;
            d_wdata = {1'b0, ((i_ff == start_ff) ? DistW'(0) : Unreachable)};
         end
         S_MARK: begin
            n_addr = NidxW'(x_ff - NodeW'(1));
            d_we = 1'b1;
            d_wdata = {1'b1, dx_ff};
         end
         S_EDGE_A, S_EDGE_B: n_addr = NidxW'(other - NodeW'(1));
         S_UPD: begin
            n_addr = NidxW'(nb_ff - NodeW'(1));
            d_we = (d_rdata[DistW-1:0] > cand_ff);
            p_we = d_we;
            d_wdata = {d_rdata[DistW], cand_ff};
            p_wdata = x_ff;
         end
         default: ;
      endcase
   end

   spd_ram #(.Width(EdgeW), .Depth(MaxEdges)) u_edges (
      .clock, .we(e_we), .addr(e_addr), .wdata(e_wdata), .rdata(e_rdata));
   spd_ram #(.Width(DistW + 1), .Depth(MaxNodes)) u_dist (
      .clock, .we(d_we), .addr(n_addr), .wdata(d_wdata), .rdata(d_rdata));
   spd_ram #(.Width(NodeW), .Depth(MaxNodes)) u_pred (
      .clock, .we(p_we), .addr(n_addr), .wdata(p_wdata), .rdata(p_rdata));

   // The scan's node read is registered, so i_ff runs one ahead of the node whose data is seen.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= NodesReset;
         etotal_ff <= '0;
         overflow_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_paddr == '0)
            count_ff <= csr_pwdata[NodeW-1:0];
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  unique case (req_func)
                     FuncClear: begin
                        etotal_ff <= '0;
                        overflow_ff <= 1'b0;
                     end
                     FuncAdd: begin
                        if (etotal_ff < EcntW'(MaxEdges)) etotal_ff <= etotal_ff + EcntW'(1);
                        else overflow_ff <= 1'b1;
                     end
                     FuncRun: begin
                        n_ff <= n_in;
                        start_ff <= (req_node_a <= n_in) ? req_node_a : '0;
                        i_ff <= NodeW'(1);
                        state_ff <= S_INIT;
                     end
                     default: ;
                  endcase
               end
            end
            S_INIT: begin
               if (i_ff == n_ff) begin
                  i_ff <= NodeW'(1);
                  best_ff <= Unreachable;
                  best_x_ff <= '0;
                  state_ff <= (start_ff == '0) ? S_EMIT : S_SCAN;
               end else i_ff <= i_ff + NodeW'(1);
            end
            S_SCAN: begin
               if (scan_better) begin
                  best_ff <= d_rdata[DistW-1:0];
                  best_x_ff <= i_ff - NodeW'(1);
               end
               if (i_ff == n_ff + NodeW'(1)) begin
                  if (best_x_ff == '0 && !scan_better) begin
                     i_ff <= NodeW'(1);
                     state_ff <= S_EMIT;
                  end else begin
                     x_ff <= scan_better ? i_ff - NodeW'(1) : best_x_ff;
                     dx_ff <= scan_better ? d_rdata[DistW-1:0] : best_ff;
                     state_ff <= S_MARK;
                  end
               end else i_ff <= i_ff + NodeW'(1);
            end
            S_MARK: begin
               e_ff <= '0;
               state_ff <= S_EDGE_RD;
            end
            S_EDGE_RD: begin
               second_ff <= 1'b0;
               if (e_ff == etotal_ff) begin
                  i_ff <= NodeW'(1);
                  best_ff <= Unreachable;
                  best_x_ff <= '0;
                  state_ff <= S_SCAN;
               end else state_ff <= S_EDGE_A;
            end
            S_EDGE_A: begin
               if ((second_ff ? hit_b : hit_a)) begin
                  nb_ff <= other;
                  cand_ff <= sum;
                  state_ff <= S_UPD;
               end else if (!second_ff) begin
                  second_ff <= 1'b1;
               end else begin
                  e_ff <= e_ff + EcntW'(1);
                  state_ff <= S_EDGE_RD;
               end
            end
            S_UPD: begin
               if (!second_ff) begin
                  second_ff <= 1'b1;
                  state_ff <= S_EDGE_B;
               end else begin
                  e_ff <= e_ff + EcntW'(1);
                  state_ff <= S_EDGE_RD;
               end
            end
            S_EDGE_B: state_ff <= S_EDGE_A;
            S_EMIT: state_ff <= S_EMIT_W;
            S_EMIT_W: begin
               if (!out_valid_ff) begin
                  out_valid_ff <= 1'b1;
                  out_node_ff <= i_ff;
                  out_dist_ff <= (start_ff == '0) ? Unreachable : d_rdata[DistW-1:0];
                  out_par_ff <= (start_ff == '0) ? '0 : p_rdata;
                  out_last_ff <= (i_ff == n_ff);
               end else if (rsp_ready) begin
                  out_valid_ff <= 1'b0;
                  if (out_last_ff) state_ff <= S_IDLE;
                  else begin
                     i_ff <= i_ff + NodeW'(1);
                     state_ff <= S_EMIT;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_emit: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (state_ff == S_EMIT_W)) else $error("result shown outside emit");
   a_etotal: assert property (@(posedge clock) disable iff (reset)
      etotal_ff <= EcntW'(MaxEdges)) else $error("edge count overflow");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken during output");
   a_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last) |=> req_ready) else $error("no idle after last");
   a_node: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_node != '0 && rsp_node <= n_ff)) else $error("bad node");
endmodule
